// ===== hw/rtl/bmpfb_pkg.sv =====
// bmpfb_pkg: shared constants and types of the bmp to frame buffer blitter
// no dependencies; imported by every module of the block
`default_nettype none

package bmpfb_pkg;

    // bmp header layout
    localparam int unsigned HDR_POS_W = 6;
    localparam logic [HDR_POS_W-1:0] HDR_LEN    = 6'd54;
    localparam logic [HDR_POS_W-1:0] WIDTH_POS  = 6'd18;
    localparam logic [HDR_POS_W-1:0] HEIGHT_POS = 6'd22;

    // field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DIM_W   = 32;
    localparam int unsigned COL_W   = 12;
    localparam int unsigned ROW_W   = 13;
    localparam int unsigned PITCH_W = 13;
    localparam int unsigned PIX_W   = 24;
    localparam int unsigned PROD_W  = ROW_W + PITCH_W;
    localparam int unsigned ADDR_W  = PROD_W + 1;

    // configuration
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_ROW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_COLUMN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH    = 2'd2;
    localparam logic [PITCH_W-1:0]   PITCH_RESET       = 13'd640;

    // position of a pixel byte within its triple
    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2
    } bmpfb_phase_t;

    // one finished pixel on its way to the address stages
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] value;
        logic             last;
    } bmpfb_pix_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bmpfb_parser.sv =====
// bmpfb_parser: header parse, pixel byte assembly, row and column tracking
// depends on bmpfb_pkg; feeds bmpfb_addr with one registered pixel per red byte
`default_nettype none

module bmpfb_parser #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [bmpfb_pkg::BYTE_W-1:0]   in_byte,
    input  wire                            in_first,
    input  wire  [bmpfb_pkg::COL_W-1:0]    origin_row,
    output bmpfb_pkg::bmpfb_pix_t          pix,
    output logic                           pix_valid,
    input  wire                            pix_ready
);
    import bmpfb_pkg::*;

    logic [HDR_POS_W-1:0] hdr_pos_reg, hdr_pos_next;
    logic [DIM_W-1:0]     width_reg, width_next;
    logic [DIM_W-1:0]     height_reg, height_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [COL_W-1:0]     frow_reg, frow_next;
    bmpfb_phase_t         phase_reg, phase_next;
    logic [BYTE_W-1:0]    blue_reg, blue_next;
    logic [BYTE_W-1:0]    green_reg, green_next;
    logic [1:0]           pad_reg, pad_next;
    logic                 done_reg, done_next;
    bmpfb_pix_t           pix_reg, pix_next;
    logic                 pix_valid_reg, pix_valid_next;

    logic                 accept;
    logic [HDR_POS_W-1:0] hdr_pos_eff;
    logic [DIM_W-1:0]     width_eff, height_eff;
    logic                 done_eff;
    logic                 in_hdr, in_pad, is_red, emit;
    logic                 col_last, row_last;
    logic [HDR_POS_W-1:0] hdr_pos_inc;
    logic                 bad_size;
    logic [1:0]           wbyte_sel, hbyte_sel;

    assign in_ready  = !pix_valid_reg || pix_ready;
    assign accept    = in_valid && in_ready;
    assign pix       = pix_reg;
    assign pix_valid = pix_valid_reg;

    // a first byte restarts the header at once
    assign hdr_pos_eff = in_first ? '0 : hdr_pos_reg;
    assign width_eff   = in_first ? '0 : width_reg;
    assign height_eff  = in_first ? '0 : height_reg;
    assign done_eff    = in_first ? 1'b0 : done_reg;

    assign in_hdr   = hdr_pos_eff < HDR_LEN;
    assign in_pad   = pad_reg != 2'd0;
    assign is_red   = !done_eff && !in_hdr && !in_pad
                      && phase_reg != PH_BLUE && phase_reg != PH_GREEN;
    assign emit     = accept && is_red;
    assign col_last = ({1'b0, col_reg} + 13'd1) == width_eff[12:0];
    assign row_last = ({1'b0, frow_reg} + 13'd1) == height_eff[12:0];
    assign hdr_pos_inc = hdr_pos_eff + 6'd1;
    // byte lane within the little-endian size words, wraps in two bits
    assign wbyte_sel = hdr_pos_eff[1:0] - WIDTH_POS[1:0];
    assign hbyte_sel = hdr_pos_eff[1:0] - HEIGHT_POS[1:0];
    // the last header byte carries no size bits, so the sizes are final here
    assign bad_size = width_eff == '0 || height_eff == '0
                      || width_eff > DIM_W'(MAX_DIM) || height_eff > DIM_W'(MAX_DIM);

    // pixel out: screen row flips the bottom-up file order
    always_comb begin
        pix_next       = pix_reg;
        pix_valid_next = pix_valid_reg;
        if (in_ready) begin
            pix_valid_next = emit;
        end
        if (emit) begin
            pix_next.row   = {1'b0, origin_row} + height_eff[12:0] - 13'd1
                             - {1'b0, frow_reg};
            pix_next.col   = col_reg;
            pix_next.value = {blue_reg, green_reg, in_byte};
            pix_next.last  = col_last && row_last;
        end
    end

    // parse state
    always_comb begin
        hdr_pos_next = hdr_pos_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        col_next     = col_reg;
        frow_next    = frow_reg;
        phase_next   = phase_reg;
        blue_next    = blue_reg;
        green_next   = green_reg;
        pad_next     = pad_reg;
        done_next    = done_reg;
        if (accept) begin
            hdr_pos_next = hdr_pos_eff;
            width_next   = width_eff;
            height_next  = height_eff;
            done_next    = done_eff;
            if (!done_eff) begin
                if (in_hdr) begin
                    // little-endian size fields
                    if (hdr_pos_eff >= WIDTH_POS && hdr_pos_eff < WIDTH_POS + 6'd4) begin
                        width_next[8*wbyte_sel +: 8] =
                            width_eff[8*wbyte_sel +: 8] | in_byte;
                    end else if (hdr_pos_eff >= HEIGHT_POS
                                 && hdr_pos_eff < HEIGHT_POS + 6'd4) begin
                        height_next[8*hbyte_sel +: 8] =
                            height_eff[8*hbyte_sel +: 8] | in_byte;
                    end
                    hdr_pos_next = hdr_pos_inc;
                    if (hdr_pos_inc == HDR_LEN) begin
                        col_next   = '0;
                        frow_next  = '0;
                        phase_next = PH_BLUE;
                        pad_next   = 2'd0;
                        if (bad_size) begin
                            done_next = 1'b1;
                        end
                    end
                end else if (in_pad) begin
                    pad_next = pad_reg - 2'd1;
                end else begin
                    case (phase_reg)
                        PH_BLUE: begin
                            blue_next  = in_byte;
                            phase_next = PH_GREEN;
                        end
                        PH_GREEN: begin
                            green_next = in_byte;
                            phase_next = PH_RED;
                        end
                        default: begin
                            phase_next = PH_BLUE;
                            if (col_last) begin
                                col_next = '0;
                                if (row_last) begin
                                    done_next = 1'b1;
                                end else begin
                                    frow_next = frow_reg + 12'd1;
                                    pad_next  = width_eff[1:0];
                                end
                            end else begin
                                col_next = col_reg + 12'd1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_pos_reg   <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            col_reg       <= '0;
            frow_reg      <= '0;
            phase_reg     <= PH_BLUE;
            blue_reg      <= '0;
            green_reg     <= '0;
            pad_reg       <= '0;
            done_reg      <= 1'b1;
            pix_valid_reg <= 1'b0;
        end else begin
            hdr_pos_reg   <= hdr_pos_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            col_reg       <= col_next;
            frow_reg      <= frow_next;
            phase_reg     <= phase_next;
            blue_reg      <= blue_next;
            green_reg     <= green_next;
            pad_reg       <= pad_next;
            done_reg      <= done_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg <= pix_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bmpfb_addr.sv =====
// bmpfb_addr: two-stage address pipe, row times pitch then column add and range check
// depends on bmpfb_pkg; drives the result channel of the blitter
`default_nettype none

module bmpfb_addr #(
    parameter int unsigned FB_ADDR_BITS = 20
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  bmpfb_pkg::bmpfb_pix_t          pix,
    input  wire                            pix_valid,
    output logic                           pix_ready,
    input  wire  [bmpfb_pkg::PITCH_W-1:0]  line_pitch,
    input  wire  [bmpfb_pkg::COL_W-1:0]    origin_column,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [FB_ADDR_BITS-1:0]        out_address,
    output logic [bmpfb_pkg::PIX_W-1:0]    out_value,
    output logic                           out_last
);
    import bmpfb_pkg::*;

    logic                 mul_valid_reg, mul_valid_next;
    logic [PROD_W-1:0]    prod_reg;
    logic [ROW_W-1:0]     csum_reg;
    logic [PIX_W-1:0]     mval_reg;
    logic                 mlast_reg;
    logic                 mul_ready;

    logic                 out_valid_reg, out_valid_next;
    logic [FB_ADDR_BITS-1:0] addr_reg;
    logic [PIX_W-1:0]     val_reg;
    logic                 last_reg;
    logic                 out_free;
    logic [ADDR_W-1:0]    addr_full;
    logic                 in_range;

    assign out_free  = !out_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || out_free;
    assign pix_ready = mul_ready;

    assign addr_full = {1'b0, prod_reg} + ADDR_W'(csum_reg);
    assign in_range  = (addr_full >> FB_ADDR_BITS) == '0;

    always_comb begin
        mul_valid_next = mul_valid_reg;
        out_valid_next = out_valid_reg;
        if (mul_ready) begin
            mul_valid_next = pix_valid;
        end
        // writes past the frame buffer are dropped here
        if (out_free) begin
            out_valid_next = mul_valid_reg && in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && pix_valid) begin
            prod_reg  <= PROD_W'(pix.row) * PROD_W'(line_pitch);
            csum_reg  <= {1'b0, origin_column} + {1'b0, pix.col};
            mval_reg  <= pix.value;
            mlast_reg <= pix.last;
        end
        if (out_free && mul_valid_reg) begin
            addr_reg <= addr_full[FB_ADDR_BITS-1:0];
            val_reg  <= mval_reg;
            last_reg <= mlast_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_address = addr_reg;
    assign out_value   = val_reg;
    assign out_last    = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bmp_to_framebuffer_blit.sv =====
// bmp_to_framebuffer_blit: top level, configuration registers and pipeline wiring
// depends on bmpfb_pkg, bmpfb_parser and bmpfb_addr
`default_nettype none

// Streams a 24-bit BMP file in, one byte per item, and produces frame buffer
// word writes. s_first_byte marks byte 0 of a file and restarts parsing on that
// very byte. Width and height come from header bytes 18..25; a file whose size
// is zero or above MAX_DIM is ignored. Each pixel (blue, green, red bytes) yields
// one write on its red byte, packed blue<<16 | green<<8 | red, at address
// (origin_row + height - 1 - file_row) * line_pitch + origin_column + column,
// so the bottom-up file lands upright on screen. Row padding of width mod 4
// bytes is skipped. Writes at or above 2^FB_ADDR_BITS are dropped, and
// m_last_pixel flags the final pixel of the image. One byte is taken every
// clock unless stalled; a pixel write passes the parser register, the row
// times pitch multiply register, and column add and range check in the output
// register. Each stage holds while the next one is full, so backpressure on
// m_ready stalls the input without losing bytes. Config registers are written
// through cfg_we / cfg_index / cfg_data, by the user while idle; unenforced.
module bmp_to_framebuffer_blit #(
    parameter int unsigned MAX_DIM      = 4096,
    parameter int unsigned FB_ADDR_BITS = 20
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // configuration write port
    input  wire                               cfg_we,
    input  wire  [bmpfb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [bmpfb_pkg::CFG_DATA_W-1:0]  cfg_data,
    // file bytes in
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [7:0]                        s_file_byte,
    input  wire                               s_first_byte,
    // pixel writes out
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [FB_ADDR_BITS-1:0]           m_pixel_address,
    output logic [23:0]                       m_pixel_value,
    output logic                              m_last_pixel
);
    import bmpfb_pkg::*;

    // configuration registers
    logic [COL_W-1:0]   origin_row_reg, origin_row_next;
    logic [COL_W-1:0]   origin_column_reg, origin_column_next;
    logic [PITCH_W-1:0] line_pitch_reg, line_pitch_next;

    // parser to address pipe
    bmpfb_pix_t pix;
    logic       pix_valid;
    logic       pix_ready;

    // register writes; an index past the list is ignored
    always_comb begin
        origin_row_next    = origin_row_reg;
        origin_column_next = origin_column_reg;
        line_pitch_next    = line_pitch_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_ORIGIN_ROW:    origin_row_next    = cfg_data[COL_W-1:0];
                CFG_ORIGIN_COLUMN: origin_column_next = cfg_data[COL_W-1:0];
                CFG_LINE_PITCH:    line_pitch_next    = cfg_data[PITCH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_row_reg    <= '0;
            origin_column_reg <= '0;
            line_pitch_reg    <= PITCH_RESET;
        end else begin
            origin_row_reg    <= origin_row_next;
            origin_column_reg <= origin_column_next;
            line_pitch_reg    <= line_pitch_next;
        end
    end

    // header, padding and pixel byte assembly
    bmpfb_parser #(
        .MAX_DIM    (MAX_DIM)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_byte    (s_file_byte),
        .in_first   (s_first_byte),
        .origin_row (origin_row_reg),
        .pix        (pix),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready)
    );

    // address computation and out-of-range drop
    bmpfb_addr #(
        .FB_ADDR_BITS (FB_ADDR_BITS)
    ) u_addr (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pix           (pix),
        .pix_valid     (pix_valid),
        .pix_ready     (pix_ready),
        .line_pitch    (line_pitch_reg),
        .origin_column (origin_column_reg),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_address   (m_pixel_address),
        .out_value     (m_pixel_value),
        .out_last      (m_last_pixel)
    );

endmodule

`default_nettype wire
